FILE: rtl/aed_pkg.sv
// ----------------------------------------------------------------------------
// aed_pkg
// Types and constants shared by the echo delay block.
// ----------------------------------------------------------------------------
package aed_pkg;

	localparam int SAMPLE_W = 16;
	localparam int DELAY_W  = 10;
	localparam int GAIN_W   = 7;
	localparam int CFG_W    = DELAY_W;

	typedef enum logic [1:0] {
		CFG_ACTIVE   = 2'd0,
		CFG_FEEDBACK = 2'd1,
		CFG_DELAY    = 2'd2,
		CFG_GAIN     = 2'd3
	} cfg_idx_t;

	localparam logic [DELAY_W-1:0] DELAY_RESET = 10'd500;
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 7'd50;
	localparam logic [GAIN_W-1:0]  GAIN_MAX    = 7'd99;

	// mix arithmetic
	localparam int GAIN_BASE   = 100;
	localparam int NUM_W       = 24;
	localparam int MAG_W       = NUM_W - 1;
	localparam int REM_W       = MAG_W + 1;
	localparam int DEN_W       = 8;
	localparam int RECIP_SHIFT = 32;
	localparam int RECIP_W     = 26;
	localparam int PROD_W      = MAG_W + RECIP_W;

	localparam logic signed [NUM_W-1:0] X_WEIGHT = 24'sd100;
	localparam logic [DEN_W-1:0]        DEN_BASE = 8'd100;

	// milliseconds to samples
	localparam int MS_PER_S       = 1000;
	localparam int FRAC_W         = 10;
	localparam int MS_RECIP_SHIFT = 30;
	localparam int MS_RECIP_W     = 21;
	localparam logic [MS_RECIP_W-1:0] MS_RECIP =
		MS_RECIP_W'(((64'd1 << MS_RECIP_SHIFT) + 64'd999) / 64'd1000);

endpackage

FILE: rtl/aed_ram.sv
// ----------------------------------------------------------------------------
// aed_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module aed_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/audio_echo_delay.sv
// ----------------------------------------------------------------------------
// audio_echo_delay
// Echo effect: weighted mix of the chain sample and a delayed sample from a
// circular store holding raw input (feedforward) or past output (feedback).
// ----------------------------------------------------------------------------
// one beat per cycle sustained through the six-stage mix pipeline while neither
// stall below holds the flow; the pipeline stalls as a whole on output back-pressure,
// and after reset and after each delay write, input is held off while the
// millisecond delay is converted to samples
// reset clears control state; the store is not swept, entries not yet written
// since reset read as zero by tracking the write position and its first wrap
// ----------------------------------------------------------------------------
module audio_echo_delay #(
	parameter int STORE_DEPTH    = 65536,
	parameter int SAMPLE_RATE_HZ = 44100
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [31:0]                 s_axis_tdata,  // chain_sample, raw_sample

	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [15:0]                 m_axis_tdata,  // mix_sample

	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [aed_pkg::CFG_W-1:0]   cfg_data
);

	localparam int AW        = $clog2(STORE_DEPTH);
	localparam int SW        = aed_pkg::SAMPLE_W;
	localparam int RATE_INT  = SAMPLE_RATE_HZ / aed_pkg::MS_PER_S;
	localparam int RATE_FRAC = SAMPLE_RATE_HZ % aed_pkg::MS_PER_S;
	localparam int RI_W      = $clog2(RATE_INT + 1);
	localparam int DB_W      = aed_pkg::DELAY_W + RI_W;
	localparam int DF_W      = aed_pkg::DELAY_W + aed_pkg::FRAC_W;
	localparam int DM_W      = DF_W + aed_pkg::MS_RECIP_W;
	localparam int DS_W      =
		$clog2(((2 ** aed_pkg::DELAY_W) - 1) * SAMPLE_RATE_HZ / aed_pkg::MS_PER_S + 1);

	localparam logic [RI_W-1:0]            RATE_INT_C  = RI_W'(RATE_INT);
	localparam logic [aed_pkg::FRAC_W-1:0] RATE_FRAC_C = aed_pkg::FRAC_W'(RATE_FRAC);
	localparam logic [AW-1:0]              LAST_POS    = AW'(STORE_DEPTH - 1);

	// configuration
	logic                          active_q;
	logic                          feedback_q;
	logic [aed_pkg::DELAY_W-1:0]   delay_ms_q;
	logic [aed_pkg::GAIN_W-1:0]    gain_q;
	logic [1:0]                    busy_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			feedback_q <= 1'b0;
			delay_ms_q <= aed_pkg::DELAY_RESET;
			gain_q     <= aed_pkg::GAIN_RESET;
			busy_q     <= 2'd2;
		end else begin
			if (cfg_valid && cfg_ready
				&& aed_pkg::cfg_idx_t'(cfg_index) == aed_pkg::CFG_DELAY) begin
				busy_q <= 2'd2;
			end else if (busy_q != 2'd0) begin
				busy_q <= busy_q - 2'd1;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (aed_pkg::cfg_idx_t'(cfg_index))
					aed_pkg::CFG_ACTIVE:   active_q   <= cfg_data[0];
					aed_pkg::CFG_FEEDBACK: feedback_q <= cfg_data[0];
					aed_pkg::CFG_DELAY:    delay_ms_q <= cfg_data;
					aed_pkg::CFG_GAIN: begin
						if (cfg_data[aed_pkg::GAIN_W-1:0] > aed_pkg::GAIN_MAX) begin
							gain_q <= aed_pkg::GAIN_MAX;
						end else begin
							gain_q <= cfg_data[aed_pkg::GAIN_W-1:0];
						end
					end
				endcase
			end
		end
	end

	// delay in samples: ms*int_part + floor(ms*frac_part/1000)
	logic [DB_W-1:0]  dbase_q;
	logic [DF_W-1:0]  dfrac_q;
	logic [AW-1:0]    d_q;
	logic [DM_W-1:0]  dm_w;
	logic [DS_W-1:0]  dsum_w;

	assign dm_w   = DM_W'(dfrac_q) * DM_W'(aed_pkg::MS_RECIP);
	assign dsum_w = DS_W'(dbase_q)
		+ DS_W'(dm_w[aed_pkg::MS_RECIP_SHIFT +: aed_pkg::DELAY_W]);

	always_ff @(posedge clk) begin
		dbase_q <= DB_W'(delay_ms_q) * DB_W'(RATE_INT_C);
		dfrac_q <= DF_W'(delay_ms_q) * DF_W'(RATE_FRAC_C);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= '0;
		end else if (32'(dsum_w) >= 32'(STORE_DEPTH)) begin
			d_q <= LAST_POS;
		end else begin
			d_q <= AW'(dsum_w);
		end
	end

	// reciprocal table, floor(2^32 / (100 + g))
	logic [aed_pkg::RECIP_W-1:0] recip_tab [0:(2 ** aed_pkg::GAIN_W)-1];

	for (genvar gi = 0; gi < 2 ** aed_pkg::GAIN_W; gi++) begin : g_recip
		localparam longint unsigned RV =
			(64'd1 << aed_pkg::RECIP_SHIFT) / (aed_pkg::GAIN_BASE + gi);
		assign recip_tab[gi] = aed_pkg::RECIP_W'(RV);
	end

	// handshake and write position
	logic adv;
	logic accept;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [AW-1:0] wp_q;
	logic          wrapped_q;
	logic [AW-1:0] rd_w;
	logic          hit_w;

	assign adv           = !v_s6 || m_axis_tready;
	assign s_axis_tready = adv && (busy_q == 2'd0);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign hit_w = wrapped_q || (wp_q >= d_q);
	assign rd_w  = (wp_q >= d_q) ? AW'(wp_q - d_q)
		: AW'((AW+1)'(wp_q) + (AW+1)'(STORE_DEPTH) - (AW+1)'(d_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
		end else if (accept) begin
			if (wp_q == LAST_POS) begin
				wp_q      <= '0;
				wrapped_q <= 1'b1;
			end else begin
				wp_q <= wp_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// store
	logic          st_we;
	logic [AW-1:0] st_waddr;
	logic [SW-1:0] st_wdata;
	logic [SW-1:0] st_rdata;

	aed_ram #(
		.WIDTH (SW),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (accept),
		.raddr (rd_w),
		.rdata (st_rdata)
	);

	// s1: read issued
	logic signed [SW-1:0] x_s1, r_s1;
	logic [AW-1:0]        wa_s1;
	logic                 hit_s1, zero_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= s_axis_tdata[SW-1:0];
			r_s1    <= s_axis_tdata[2*SW-1:SW];
			wa_s1   <= wp_q;
			hit_s1  <= hit_w;
			zero_s1 <= (d_q == '0);
		end
	end

	// s2: pick delayed sample, weight both
	logic signed [SW-1:0]             p_w;
	logic signed [aed_pkg::NUM_W-1:0] xm_s2, gp_s2;
	logic signed [SW-1:0]             x_s2, r_s2;
	logic [AW-1:0]                    wa_s2;

	always_comb begin
		if (zero_s1) begin
			p_w = feedback_q ? x_s1 : r_s1;
		end else if (hit_s1) begin
			p_w = st_rdata;
		end else begin
			p_w = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xm_s2 <= aed_pkg::NUM_W'(x_s1) * aed_pkg::X_WEIGHT;
			gp_s2 <= aed_pkg::NUM_W'(p_w) * signed'(aed_pkg::NUM_W'(gain_q));
			x_s2  <= x_s1;
			r_s2  <= r_s1;
			wa_s2 <= wa_s1;
		end
	end

	// s3: sum, magnitude, divisor and its reciprocal
	logic signed [aed_pkg::NUM_W-1:0] n_w;
	logic [aed_pkg::MAG_W-1:0]        mag_s3;
	logic                             neg_s3;
	logic [aed_pkg::DEN_W-1:0]        den_s3;
	logic [aed_pkg::RECIP_W-1:0]      recip_s3;
	logic signed [SW-1:0]             x_s3, r_s3;
	logic [AW-1:0]                    wa_s3;

	assign n_w = xm_s2 + gp_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s3   <= n_w[aed_pkg::NUM_W-1];
			mag_s3   <= n_w[aed_pkg::NUM_W-1] ? aed_pkg::MAG_W'(-n_w)
				: aed_pkg::MAG_W'(n_w);
			den_s3   <= aed_pkg::DEN_BASE + aed_pkg::DEN_W'(gain_q);
			recip_s3 <= recip_tab[gain_q];
			x_s3     <= x_s2;
			r_s3     <= r_s2;
			wa_s3    <= wa_s2;
		end
	end

	// s4: quotient estimate, low by at most one
	logic [aed_pkg::PROD_W-1:0] qp_w;
	logic [SW-1:0]              qe_s4;
	logic [aed_pkg::MAG_W-1:0]  mag_s4;
	logic [aed_pkg::DEN_W-1:0]  den_s4;
	logic                       neg_s4;
	logic signed [SW-1:0]       x_s4, r_s4;
	logic [AW-1:0]              wa_s4;

	assign qp_w = aed_pkg::PROD_W'(mag_s3) * aed_pkg::PROD_W'(recip_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			qe_s4  <= qp_w[aed_pkg::RECIP_SHIFT +: SW];
			mag_s4 <= mag_s3;
			den_s4 <= den_s3;
			neg_s4 <= neg_s3;
			x_s4   <= x_s3;
			r_s4   <= r_s3;
			wa_s4  <= wa_s3;
		end
	end

	// s5: remainder check and correction
	logic [aed_pkg::REM_W-1:0] qd_w, rem_w;
	logic [SW-1:0]             q_s5;
	logic                      neg_s5;
	logic signed [SW-1:0]      x_s5, r_s5;
	logic [AW-1:0]             wa_s5;

	assign qd_w  = aed_pkg::REM_W'(qe_s4) * aed_pkg::REM_W'(den_s4);
	assign rem_w = aed_pkg::REM_W'(mag_s4) - qd_w;

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s5   <= qe_s4 + SW'(rem_w >= aed_pkg::REM_W'(den_s4));
			neg_s5 <= neg_s4;
			x_s5   <= x_s4;
			r_s5   <= r_s4;
			wa_s5  <= wa_s4;
		end
	end

	// s6: sign, bypass, output register and store write
	logic signed [SW:0]   qs_w;
	logic signed [SW-1:0] y_w;
	logic signed [SW-1:0] y_s6;

	assign qs_w = signed'({1'b0, q_s5});

	always_comb begin
		if (!active_q) begin
			y_w = x_s5;
		end else if (neg_s5) begin
			y_w = SW'(-qs_w);
		end else begin
			y_w = SW'(qs_w);
		end
	end

	assign st_we    = adv && v_s5;
	assign st_waddr = wa_s5;
	assign st_wdata = feedback_q ? y_w : r_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s6 <= y_w;
		end
	end

	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata  = y_s6;

endmodule
